// ----- sv/clcd_pkg.sv -----
// Shared types, codes and constants of the character LCD write sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package clcd_pkg;

  // Defaults
  localparam int NUMBER_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  // Request action codes
  localparam logic [2:0] ACT_CMD    = 3'd0;
  localparam logic [2:0] ACT_DATA   = 3'd1;
  localparam logic [2:0] ACT_NUMBER = 3'd2;
  localparam logic [2:0] ACT_CURSOR = 3'd3;
  localparam logic [2:0] ACT_INIT   = 3'd4;

  // Panel commands and timing
  localparam logic [7:0]  CMD_HOME    = 8'h02;
  localparam logic [7:0]  CMD_FUNC    = 8'h28;
  localparam logic [7:0]  CMD_DISP    = 8'h0C;
  localparam logic [7:0]  CMD_ENTRY   = 8'h06;
  localparam logic [7:0]  CMD_CLEAR   = 8'h01;
  localparam logic [7:0]  NIB_WAKE    = 8'h02;
  localparam logic [7:0]  DDRAM_BASE  = 8'd128;
  localparam logic [7:0]  ROW1_OFFSET = 8'h40;
  localparam logic [7:0]  ASCII_ZERO  = 8'h30;
  localparam logic [15:0] POWER_WAIT  = 16'd40000;
  localparam logic [10:0] SHORT_WAIT  = 11'd45;
  localparam logic [10:0] CLEAR_WAIT  = 11'd2000;

  // Init list steps
  localparam int          INIT_IDX_W     = 3;
  localparam logic [2:0]  INIT_WAKE_NIB  = 3'd0;
  localparam logic [2:0]  INIT_HOME      = 3'd1;
  localparam logic [2:0]  INIT_FUNC      = 3'd2;
  localparam logic [2:0]  INIT_DISP      = 3'd3;
  localparam logic [2:0]  INIT_ENTRY     = 3'd4;
  localparam logic [2:0]  INIT_CLEAR     = 3'd5;

  typedef enum logic [1:0] {
    JOB_BYTE = 2'd0,
    JOB_NUM  = 2'd1,
    JOB_INIT = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] data;
  } job_hdr_t;

  localparam int HDR_W = $bits(job_hdr_t);

  typedef struct packed {
    logic        single;  // one strobe even on the nibble bus
    logic [7:0]  data;
    logic [15:0] wb;
    logic [10:0] wa;
  } init_entry_t;

  function automatic init_entry_t init_step(input logic [INIT_IDX_W-1:0] idx,
                                            input logic nibble_bus);
    init_entry_t e;
    e = '{single: 1'b0, data: CMD_CLEAR, wb: 16'd0, wa: CLEAR_WAIT};
    case (idx)
      INIT_WAKE_NIB: e = '{single: 1'b1, data: NIB_WAKE, wb: POWER_WAIT, wa: 11'd0};
      INIT_HOME:     e = '{single: 1'b0, data: CMD_HOME,
                           wb: nibble_bus ? 16'd0 : POWER_WAIT, wa: 11'd0};
      INIT_FUNC:     e = '{single: 1'b0, data: CMD_FUNC, wb: POWER_WAIT, wa: SHORT_WAIT};
      INIT_DISP:     e = '{single: 1'b0, data: CMD_DISP, wb: 16'd0, wa: SHORT_WAIT};
      INIT_ENTRY:    e = '{single: 1'b0, data: CMD_ENTRY, wb: 16'd0, wa: SHORT_WAIT};
      INIT_CLEAR:    e = '{single: 1'b0, data: CMD_CLEAR, wb: 16'd0, wa: CLEAR_WAIT};
      default:       e = '{single: 1'b0, data: CMD_CLEAR, wb: 16'd0, wa: CLEAR_WAIT};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- sv/clcd_front.sv -----
// Front end: accepts request words and classifies them into jobs.
// Depends on clcd_pkg.
`default_nettype none

module clcd_front
  import clcd_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              action,
  input  wire logic [31:0]             value,
  input  wire logic [5:0]              column,
  input  wire logic                    row,
  input  wire logic                    q_full,
  output logic                         push,
  output job_hdr_t                     hdr,
  output logic [NUMBER_WIDTH-1:0]      num
);

  logic [NUMBER_WIDTH+31:0] value_ext;
  logic                     known;

  // zero-extend or mask the number to NUMBER_WIDTH
  assign value_ext = {{NUMBER_WIDTH{1'b0}}, value};
  assign num       = value_ext[NUMBER_WIDTH-1:0];

  assign in_stall = q_full;

  always_comb begin
    hdr   = '{kind: JOB_BYTE, rs: 1'b0, data: value[7:0]};
    known = 1'b1;
    case (action)
      ACT_CMD:    hdr = '{kind: JOB_BYTE, rs: 1'b0, data: value[7:0]};
      ACT_DATA:   hdr = '{kind: JOB_BYTE, rs: 1'b1, data: value[7:0]};
      ACT_NUMBER: hdr = '{kind: JOB_NUM, rs: 1'b1, data: 8'd0};
      ACT_CURSOR: hdr = '{kind: JOB_BYTE, rs: 1'b0,
                          data: DDRAM_BASE + {2'b00, column} + (row ? ROW1_OFFSET : 8'd0)};
      ACT_INIT:   hdr = '{kind: JOB_INIT, rs: 1'b0, data: 8'd0};
      default:    known = 1'b0;  // unused codes are swallowed
    endcase
  end

  assign push = in_valid && !q_full && known;

endmodule

`default_nettype wire

// ----- sv/clcd_queue.sv -----
// Short job queue between front and back ends.
// Depends on clcd_pkg for the default width and depth.
`default_nettype none

module clcd_queue
  import clcd_pkg::*;
#(
  parameter int WIDTH = HDR_W,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign dout      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/clcd_back.sv -----
// Back end: runs jobs into strobe words (decimal conversion, init list,
// nibble split) and holds the output register. Depends on clcd_pkg.
`default_nettype none

module clcd_back
  import clcd_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    bus_mode,
  input  wire logic                    job_valid,
  input  wire job_hdr_t                job_hdr,
  input  wire logic [NUMBER_WIDTH-1:0] job_num,
  output logic                         job_pop,
  input  wire logic                    out_stall,
  output logic                         out_valid,
  output logic                         register_select,
  output logic [7:0]                   bus_value,
  output logic [15:0]                  wait_before_us,
  output logic [10:0]                  wait_after_us,
  output logic                         last_strobe
);

  localparam int DIGITS = (NUMBER_WIDTH * 31) / 100 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNT_W  = $clog2(NUMBER_WIDTH + 1);
  localparam int DIG_W  = $clog2(DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(NUMBER_WIDTH);
  localparam logic [DIG_W-1:0] DIG_INIT = DIG_W'(DIGITS);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_ILOAD = 5'b01000,
    ST_BYTE  = 5'b10000
  } back_state_t;

  back_state_t             state;
  job_kind_t               src;
  logic [NUMBER_WIDTH-1:0] bin;
  logic [BCD_W-1:0]        bcd;
  logic [BCD_W-1:0]        bcd_adj;
  logic [CNT_W-1:0]        bit_cnt;
  logic [DIG_W-1:0]        dig_left;
  logic [INIT_IDX_W-1:0]   init_idx;
  init_entry_t             entry;
  logic [3:0]              top_digit;
  logic [7:0]              digit_byte;

  // byte being sent
  logic        cur_rs;
  logic [7:0]  cur_byte;
  logic [15:0] cur_wb;
  logic [10:0] cur_wa;
  logic        cur_last;
  logic        cur_single;
  logic        phase;

  logic        split;
  logic        out_free;
  logic [7:0]  strb_bus;
  logic [15:0] strb_wb;
  logic [10:0] strb_wa;
  logic        strb_last;

  // double-dabble add-3 on every digit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign top_digit  = bcd[BCD_W-1 -: 4];
  assign digit_byte = ASCII_ZERO | {4'h0, top_digit};
  assign entry      = init_step(init_idx, bus_mode);

  assign split    = bus_mode && !cur_single;
  assign out_free = !out_valid || !out_stall;
  assign job_pop  = (state == ST_IDLE) && job_valid;

  always_comb begin
    if (!split) begin
      strb_bus  = cur_byte;
      strb_wb   = cur_wb;
      strb_wa   = cur_wa;
      strb_last = cur_last;
    end else if (!phase) begin
      strb_bus  = {4'h0, cur_byte[7:4]};
      strb_wb   = cur_wb;
      strb_wa   = 11'd0;
      strb_last = 1'b0;
    end else begin
      strb_bus  = {4'h0, cur_byte[3:0]};
      strb_wb   = 16'd0;
      strb_wa   = cur_wa;
      strb_last = cur_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      // in ST_BYTE the output register is refilled whenever it frees
      if (out_valid && !out_stall && state != ST_BYTE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            src <= job_hdr.kind;
            case (job_hdr.kind)
              JOB_NUM: begin
                bin     <= job_num;
                bcd     <= '0;
                bit_cnt <= CNT_INIT;
                state   <= ST_CONV;
              end
              JOB_INIT: begin
                init_idx <= bus_mode ? INIT_WAKE_NIB : INIT_HOME;
                state    <= ST_ILOAD;
              end
              default: begin
                cur_rs     <= job_hdr.rs;
                cur_byte   <= job_hdr.data;
                cur_wb     <= 16'd0;
                cur_wa     <= 11'd0;
                cur_last   <= 1'b1;
                cur_single <= 1'b0;
                state      <= ST_BYTE;
              end
            endcase
          end
        end
        ST_CONV: begin
          bcd     <= {bcd_adj[BCD_W-2:0], bin[NUMBER_WIDTH-1]};
          bin     <= {bin[NUMBER_WIDTH-2:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == CNT_W'(1)) begin
            dig_left <= DIG_INIT;
            state    <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          bcd      <= {bcd[BCD_W-5:0], 4'h0};
          dig_left <= dig_left - 1'b1;
          // leading zeros dropped, but a lone zero is still sent
          if (top_digit != 4'd0 || dig_left == DIG_W'(1)) begin
            cur_rs     <= 1'b1;
            cur_byte   <= digit_byte;
            cur_wb     <= 16'd0;
            cur_wa     <= 11'd0;
            cur_last   <= (dig_left == DIG_W'(1));
            cur_single <= 1'b0;
            state      <= ST_BYTE;
          end
        end
        ST_ILOAD: begin
          cur_rs     <= 1'b0;
          cur_byte   <= entry.data;
          cur_wb     <= entry.wb;
          cur_wa     <= entry.wa;
          cur_single <= entry.single;
          cur_last   <= (init_idx == INIT_CLEAR);
          state      <= ST_BYTE;
        end
        ST_BYTE: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            register_select <= cur_rs;
            bus_value       <= strb_bus;
            wait_before_us  <= strb_wb;
            wait_after_us   <= strb_wa;
            last_strobe     <= strb_last;
            if (split && !phase) begin
              phase <= 1'b1;
            end else begin
              phase <= 1'b0;
              case (src)
                JOB_NUM: begin
                  if (dig_left != '0) begin
                    cur_byte <= digit_byte;
                    cur_last <= (dig_left == DIG_W'(1));
                    bcd      <= {bcd[BCD_W-5:0], 4'h0};
                    dig_left <= dig_left - 1'b1;
                  end else begin
                    state <= ST_IDLE;
                  end
                end
                JOB_INIT: begin
                  if (init_idx == INIT_CLEAR) begin
                    state <= ST_IDLE;
                  end else begin
                    init_idx <= init_idx + 1'b1;
                    state    <= ST_ILOAD;
                  end
                end
                default: state <= ST_IDLE;
              endcase
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/char_lcd_write_sequencer.sv -----
// Character LCD write sequencer, top level: front end, job queue, back end
// and the bus mode register. Depends on clcd_pkg, clcd_front, clcd_queue, clcd_back.
//
// Use:
//  - Request words (action, value, column, row) enter on in_valid/in_stall.
//    Each becomes one or more strobe words (register_select, bus_value,
//    wait_before_us, wait_after_us, last_strobe) on out_valid/out_stall;
//    last_strobe marks the final strobe of a request. Unused action codes
//    are taken and produce nothing.
//  - bus_mode is written through cfg_we/cfg_wdata (0 = 8-bit, 1 = 4-bit);
//    the user must write it only while the block is idle; the block does not enforce this.
//  - Order: a taken byte request passes job pickup and the output register
//    before out_valid rises. A number first runs the converter over all
//    NUMBER_WIDTH bits, then scans digit places up to its first digit
//    (leading zeros plus one, at most DIGITS). Digits then leave one strobe
//    per cycle unless stalled; each init command is loaded before its strobes.
//  - Throughput: one strobe per cycle at best, while out_stall is low. The
//    back end works one job at a time; the two-word queue lets the front
//    end keep taking words meanwhile.
//  - Reset (rst, synchronous): queue emptied, back end idle, no output
//    word valid, bus_mode back to 8-bit.
//  - When the receiver stalls, the output word holds and the back end waits before its next strobe;
//    once the queue fills, in_stall rises.
`default_nettype none

module char_lcd_write_sequencer
  import clcd_pkg::*;
#(
  parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  action,
  input  wire logic [31:0] value,
  input  wire logic [5:0]  column,
  input  wire logic        row,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             register_select,
  output logic [7:0]       bus_value,
  output logic [15:0]      wait_before_us,
  output logic [10:0]      wait_after_us,
  output logic             last_strobe
);

  localparam int JOB_W = HDR_W + NUMBER_WIDTH;

  logic                    bus_mode;   // 1 = nibble bus
  logic                    push;
  logic                    q_full;
  logic                    q_not_empty;
  logic                    pop;
  job_hdr_t                front_hdr;
  logic [NUMBER_WIDTH-1:0] front_num;
  logic [JOB_W-1:0]        q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_mode <= 1'b0;
    end else if (cfg_we) begin
      bus_mode <= cfg_wdata;
    end
  end

  clcd_front #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .value    (value),
    .column   (column),
    .row      (row),
    .q_full   (q_full),
    .push     (push),
    .hdr      (front_hdr),
    .num      (front_num)
  );

  // job word: header on top, number below
  clcd_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       ({front_hdr, front_num}),
    .full      (q_full),
    .pop       (pop),
    .dout      (q_dout),
    .not_empty (q_not_empty)
  );

  clcd_back #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_back (
    .clk             (clk),
    .rst             (rst),
    .bus_mode        (bus_mode),
    .job_valid       (q_not_empty),
    .job_hdr         (job_hdr_t'(q_dout[JOB_W-1 -: HDR_W])),
    .job_num         (q_dout[NUMBER_WIDTH-1:0]),
    .job_pop         (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .register_select (register_select),
    .bus_value       (bus_value),
    .wait_before_us  (wait_before_us),
    .wait_after_us   (wait_after_us),
    .last_strobe     (last_strobe)
  );

endmodule

`default_nettype wire

// ----- sv/clcd_checker.sv -----
// Port-level checks of the character LCD write sequencer, bound to the top.
// Depends on clcd_pkg and char_lcd_write_sequencer.
`default_nettype none

module clcd_checker
  import clcd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        register_select,
  input wire logic [7:0]  bus_value,
  input wire logic [15:0] wait_before_us,
  input wire logic [10:0] wait_after_us,
  input wire logic        last_strobe
);

  // a stalled word stays
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(bus_value) && $stable(last_strobe)
                              && $stable(register_select))
    else $error("output word changed while stalled");

  // nothing valid straight after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // data strobes never carry waits; only init commands do
  a_data_nowait: assert property (@(posedge clk) disable iff (rst)
    out_valid && register_select |-> wait_before_us == 16'd0 && wait_after_us == 11'd0)
    else $error("wait on a data strobe");

  a_wait_val: assert property (@(posedge clk) disable iff (rst)
    out_valid && wait_before_us != 16'd0 |-> wait_before_us == POWER_WAIT && !last_strobe)
    else $error("bad power-up wait");

endmodule

bind char_lcd_write_sequencer clcd_checker u_clcd_checker (.*);

`default_nettype wire
